### rtl/core/mpdw_pkg.sv
// Package for the multi-pin debounced wait block.
// Holds register map, field widths and request codes; no dependencies.

package mpdw_pkg;

   // Register map (index = paddr / 4)
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_IDX_PIN_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_IDX_TARGET       = 3'd1;
   localparam logic [2:0] CSR_IDX_DEBOUNCE     = 3'd2;
   localparam logic [2:0] CSR_IDX_TIMEOUT      = 3'd3;
   localparam logic [2:0] CSR_IDX_TIMEOUT_EN   = 3'd4;

   // Field widths
   localparam int PIN_W      = 8;
   localparam int DEBOUNCE_W = 16;
   localparam int ELAPSED_W  = 32;
   localparam int PIN_NUM_W  = 4;

   // Reset value of the debounce length in ticks
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd2;

   // Saturation limits
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX = '1;
   localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX  = '1;

   // Request kinds carried on req_tuser
   typedef enum logic [0:0] {
      REQ_TICK = 1'b0,
      REQ_ARM  = 1'b1
   } req_kind_type;

endpackage

### rtl/core/multi_pin_debounced_wait.sv
// Top level of the multi-pin debounced wait block.
// Depends on mpdw_pkg for the register map, widths and request codes.

// An arm request (tuser = 1) starts a wait; each tick request (tuser = 0)
// carries one sampled pin vector. Every enabled pin counts consecutive
// ticks at its target level; the wait ends with the lowest pin whose match
// has lasted debounce_ticks, or with a timeout result (pin 0, timed_out 1)
// once the elapsed ticks exceed timeout_ticks and the lowest enabled pin has
// not qualified. The block takes one request per clock cycle while
// req_tready is high. A request passes an input register and one pass of
// per-pin counter logic that updates all pins in parallel; its result goes
// into the output register, or into the skid entry while the output is
// held. A two-entry output buffer lets input transfers continue while one
// result waits; req_tready falls only when both entries and the input
// register are occupied. The user must write configuration through the
// APB-style port while no request is in flight; the block does not check it.

module multi_pin_debounced_wait
   import mpdw_pkg::*;
#(
   parameter int NUM_PINS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] pin_levels
   input  logic [0:0]            req_tuser,   // [0] req_type
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [3:0] matched_pin, [7:4] zero
   output logic [0:0]            rsp_tuser,   // [0] timed_out
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Only the first eight pins have sample and mask bits
   localparam int PIN_COUNT = (NUM_PINS < PIN_W) ? NUM_PINS : PIN_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [PIN_W-1:0]      pin_enable_mask_ff;
   logic [PIN_W-1:0]      target_levels_ff;
   logic [DEBOUNCE_W-1:0] debounce_ticks_ff;
   logic [ELAPSED_W-1:0]  timeout_ticks_ff;
   logic                  timeout_enable_ff;
   logic                  csr_write;
   logic [2:0]            csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   // Write registers on a completed write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_enable_mask_ff <= '0;
         target_levels_ff   <= '0;
         debounce_ticks_ff  <= DEBOUNCE_RESET;
         timeout_ticks_ff   <= '0;
         timeout_enable_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IDX_PIN_ENABLE: pin_enable_mask_ff <= csr_pwdata[PIN_W-1:0];
            CSR_IDX_TARGET:     target_levels_ff   <= csr_pwdata[PIN_W-1:0];
            CSR_IDX_DEBOUNCE:   debounce_ticks_ff  <= csr_pwdata[DEBOUNCE_W-1:0];
            CSR_IDX_TIMEOUT:    timeout_ticks_ff   <= csr_pwdata[ELAPSED_W-1:0];
            CSR_IDX_TIMEOUT_EN: timeout_enable_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         CSR_IDX_PIN_ENABLE: csr_prdata = {24'd0, pin_enable_mask_ff};
         CSR_IDX_TARGET:     csr_prdata = {24'd0, target_levels_ff};
         CSR_IDX_DEBOUNCE:   csr_prdata = {16'd0, debounce_ticks_ff};
         CSR_IDX_TIMEOUT:    csr_prdata = timeout_ticks_ff;
         CSR_IDX_TIMEOUT_EN: csr_prdata = {31'd0, timeout_enable_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic               in_valid_ff;
   req_kind_type       in_kind_ff;
   logic [PIN_W-1:0]   in_levels_ff;
   logic               skid_valid_ff;
   logic               advance;
   logic               req_xfer;

   assign advance    = in_valid_ff & ~skid_valid_ff;
   assign req_tready = ~in_valid_ff | ~skid_valid_ff;
   assign req_xfer   = req_tvalid & req_tready;

   // Capture a request on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_xfer) begin
         in_kind_ff   <= req_kind_type'(req_tuser[0]);
         in_levels_ff <= req_tdata;
      end
   end

   // ---------------------------------------------------------------
   // Wait state and per-pin trackers
   // ---------------------------------------------------------------
   logic                  waiting_ff;
   logic [ELAPSED_W-1:0]  elapsed_ff;
   logic [PIN_COUNT-1:0]  tracking_ff;
   logic [DEBOUNCE_W-1:0] stable_ff [PIN_COUNT];

   logic [PIN_COUNT-1:0]  tracking_in;
   logic [DEBOUNCE_W-1:0] stable_in [PIN_COUNT];
   logic [PIN_COUNT-1:0]  qualify;
   logic [PIN_COUNT-1:0]  enabled;
   logic                  tick;
   logic                  expired;

   assign tick    = advance & (in_kind_ff == REQ_TICK) & waiting_ff;
   assign expired = timeout_enable_ff & (elapsed_ff > timeout_ticks_ff);

   // Update every enabled pin in parallel
   always_comb begin
      for (int i = 0; i < PIN_COUNT; i++) begin
         enabled[i]     = pin_enable_mask_ff[i];
         tracking_in[i] = tracking_ff[i];
         stable_in[i]   = stable_ff[i];
         qualify[i]     = 1'b0;
         if (enabled[i]) begin
            if (in_levels_ff[i] == target_levels_ff[i]) begin
               tracking_in[i] = 1'b1;
               if (!tracking_ff[i]) begin
                  stable_in[i] = '0;
               end else if (stable_ff[i] != DEBOUNCE_MAX) begin
                  stable_in[i] = stable_ff[i] + 1'b1;
               end
               qualify[i] = (stable_in[i] >= debounce_ticks_ff);
            end else begin
               tracking_in[i] = 1'b0;
            end
         end
      end
   end

   // Pick the lowest qualifying pin and the lowest enabled pin
   logic [PIN_NUM_W-1:0] lowest_pin;
   logic                 first_qualifies;
   logic                 res_valid;
   logic [PIN_NUM_W-1:0] res_pin;
   logic                 res_timed_out;

   always_comb begin
      lowest_pin      = '0;
      first_qualifies = 1'b0;
      for (int i = PIN_COUNT - 1; i >= 0; i--) begin
         if (qualify[i]) begin
            lowest_pin = PIN_NUM_W'(i + 1);
         end
         if (enabled[i]) begin
            first_qualifies = qualify[i];
         end
      end
      res_valid     = 1'b0;
      res_pin       = '0;
      res_timed_out = 1'b0;
      if (tick) begin
         if (expired && (|enabled)) begin
            res_valid = 1'b1;
            if (first_qualifies) begin
               res_pin = lowest_pin;
            end else begin
               res_timed_out = 1'b1;
            end
         end else if (|qualify) begin
            res_valid = 1'b1;
            res_pin   = lowest_pin;
         end
      end
   end

   // Advance the wait state
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff  <= 1'b0;
         elapsed_ff  <= '0;
         tracking_ff <= '0;
      end else if (advance && in_kind_ff == REQ_ARM) begin
         waiting_ff  <= 1'b1;
         elapsed_ff  <= '0;
         tracking_ff <= '0;
      end else if (tick) begin
         if (elapsed_ff != ELAPSED_MAX) begin
            elapsed_ff <= elapsed_ff + 1'b1;
         end
         tracking_ff <= tracking_in;
         if (res_valid) begin
            waiting_ff <= 1'b0;
         end
      end
   end

   // Counters are only read while their pin is tracking
   always_ff @(posedge clock) begin
      if (tick) begin
         for (int i = 0; i < PIN_COUNT; i++) begin
            stable_ff[i] <= stable_in[i];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register with skid entry
   // ---------------------------------------------------------------
   logic                 out_valid_ff;
   logic [PIN_NUM_W-1:0] out_pin_ff;
   logic                 out_timed_out_ff;
   logic [PIN_NUM_W-1:0] skid_pin_ff;
   logic                 skid_timed_out_ff;
   logic                 out_free;

   assign out_free = ~out_valid_ff | rsp_tready;

   // Load results, drain the skid entry first
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
      if (out_free) begin
         if (skid_valid_ff) begin
            out_pin_ff       <= skid_pin_ff;
            out_timed_out_ff <= skid_timed_out_ff;
         end else if (res_valid) begin
            out_pin_ff       <= res_pin;
            out_timed_out_ff <= res_timed_out;
         end
      end else if (res_valid) begin
         skid_pin_ff       <= res_pin;
         skid_timed_out_ff <= res_timed_out;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8 - PIN_NUM_W){1'b0}}, out_pin_ff};
   assign rsp_tuser  = out_timed_out_ff;

endmodule

### sim/multi_pin_debounced_wait_tb.sv
// Self-checking testbench for multi_pin_debounced_wait: drives arm and tick transfers,
// predicts each wait outcome in a local model and checks every result transfer.
// Depends on mpdw_pkg and the multi_pin_debounced_wait RTL only.
`timescale 1ns / 100ps

module multi_pin_debounced_wait_tb;
   import mpdw_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      req_kind_type     kind;
      logic [PIN_W-1:0] levels;
   } pin_request_type;

   typedef struct packed {
      logic [PIN_NUM_W-1:0] pin;
      logic                 timed_out;
   } wait_outcome_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, known from time zero
   logic             req_tvalid  = 1'b0;
   logic [7:0]       req_tdata   = '0;
   logic [0:0]       req_tuser   = '0;
   logic             rsp_tready  = 1'b0;
   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]      csr_pwdata  = '0;

   // block outputs
   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // register copies used for prediction
   logic [PIN_W-1:0]      cfg_enable     = '0;
   logic [PIN_W-1:0]      cfg_target     = '0;
   logic [DEBOUNCE_W-1:0] cfg_debounce   = DEBOUNCE_RESET;
   logic [ELAPSED_W-1:0]  cfg_timeout    = '0;
   logic                  cfg_timeout_en = 1'b0;

   // predicted wait state
   logic                  wait_active  = 1'b0;
   logic [ELAPSED_W-1:0]  wait_elapsed = '0;
   logic [PIN_W-1:0]      pin_matching = '0;
   logic [DEBOUNCE_W-1:0] pin_run_len [PIN_W] = '{default: '0};

   pin_request_type  request_q [$];
   wait_outcome_type outcome_q [$];

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_pause     = 0;
   int unsigned take_pause     = 0;
   int unsigned hold_count     = 0;
   logic        idle_on        = 1'b1;
   logic        hold_request   = 1'b0;
   logic        hold_done      = 1'b0;

   multi_pin_debounced_wait u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] pin_levels
      .req_tuser   (req_tuser),    // [0] req_type
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [3:0] matched_pin, [7:4] zero
      .rsp_tuser   (rsp_tuser),    // [0] timed_out
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the predicted wait by one accepted request; queue an outcome when it ends.
   task automatic predict_wait_step(input req_kind_type kind, input logic [PIN_W-1:0] levels);
      logic [ELAPSED_W-1:0] now;
      logic                 expired;
      logic                 ended;
      wait_outcome_type     outcome;
      ended = 1'b0;
      outcome = '0;
      if (kind == REQ_ARM) begin
         wait_active  = 1'b1;
         wait_elapsed = '0;
         pin_matching = '0;
         for (int i = 0; i < PIN_W; i++) pin_run_len[i] = '0;
      end else if (wait_active) begin
         now = wait_elapsed;
         if (wait_elapsed != ELAPSED_MAX) wait_elapsed = wait_elapsed + 1'b1;
         expired = cfg_timeout_en && (now > cfg_timeout);
         // scan lowest pin first; the timeout is tested after each pin that fails
         for (int i = 0; i < PIN_W && !ended; i++) begin
            if (cfg_enable[i]) begin
               if (levels[i] == cfg_target[i]) begin
                  if (!pin_matching[i]) begin
                     pin_matching[i] = 1'b1;
                     pin_run_len[i]  = '0;
                  end else if (pin_run_len[i] != DEBOUNCE_MAX) begin
                     pin_run_len[i] = pin_run_len[i] + 1'b1;
                  end
                  if (pin_run_len[i] >= cfg_debounce) begin
                     outcome.pin = PIN_NUM_W'(i + 1);
                     ended = 1'b1;
                  end
               end else begin
                  pin_matching[i] = 1'b0;
               end
               if (!ended && expired) begin
                  outcome.pin       = '0;
                  outcome.timed_out = 1'b1;
                  ended = 1'b1;
               end
            end
         end
         if (ended) begin
            wait_active = 1'b0;
            outcome_q.push_back(outcome);
         end
      end
   endtask

   function automatic int unsigned draw_pause();
      if (!idle_on) return 0;
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch on %s at %0t: expected %0h, actual %0h", what, $realtime, want, got);
   endtask

   // Request driver: account for the transfer, then offer the next item after its pause.
   always @(posedge clock) begin : request_driver
      pin_request_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_pause <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_wait_step(req_kind_type'(req_tuser), req_tdata);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_pause != 0) begin
               send_pause <= send_pause - 1;
               req_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
               next_req = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_req.kind;
               req_tdata  <= next_req.levels;
               send_pause <= draw_pause();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each transfer against the oldest outcome, then pace tready.
   always @(posedge clock) begin : result_monitor
      wait_outcome_type want;
      int unsigned      pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_pause <= 0;
         hold_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               note_mismatch("unexpected result", 8'h00, rsp_tdata);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tdata !== {4'h0, want.pin})
                  note_mismatch("matched_pin", {4'h0, want.pin}, rsp_tdata);
               if (rsp_tuser[0] !== want.timed_out)
                  note_mismatch("timed_out", {7'h0, want.timed_out}, {7'h0, rsp_tuser[0]});
            end
         end
         if (hold_count != 0) begin
            hold_count <= hold_count - 1;
            rsp_tready <= (hold_count == 1);
         end else if (hold_request && !hold_done) begin
            // long hold so the block fills up and stalls its input
            hold_done  <= 1'b1;
            hold_count <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            pause = draw_pause();
            take_pause <= pause;
            rsp_tready <= (pause == 0);
         end else if (take_pause != 0) begin
            take_pause <= take_pause - 1;
            rsp_tready <= (take_pause == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Write one register through setup and access cycles; mirror it in the predictor.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_IDX_PIN_ENABLE: cfg_enable     = value[PIN_W-1:0];
         CSR_IDX_TARGET:     cfg_target     = value[PIN_W-1:0];
         CSR_IDX_DEBOUNCE:   cfg_debounce   = value[DEBOUNCE_W-1:0];
         CSR_IDX_TIMEOUT:    cfg_timeout    = value[ELAPSED_W-1:0];
         CSR_IDX_TIMEOUT_EN: cfg_timeout_en = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] enable, input logic [7:0] target,
                                 input logic [15:0] debounce, input logic [31:0] timeout,
                                 input logic timeout_en);
      csr_write(CSR_IDX_PIN_ENABLE, {24'h0, enable});
      csr_write(CSR_IDX_TARGET, {24'h0, target});
      csr_write(CSR_IDX_DEBOUNCE, {16'h0, debounce});
      csr_write(CSR_IDX_TIMEOUT, timeout);
      csr_write(CSR_IDX_TIMEOUT_EN, {31'h0, timeout_en});
   endtask

   task automatic queue_request(input req_kind_type kind, input logic [PIN_W-1:0] levels);
      request_q.push_back('{kind, levels});
      queued_count++;
   endtask

   // Queue arm-led sequences of ticks near the target levels with flicker and noise.
   task automatic queue_wait_sequences(input int unsigned count, input int unsigned run_max);
      int unsigned      made;
      int unsigned      run_len;
      logic [PIN_W-1:0] spoil;
      logic [PIN_W-1:0] levels;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) == 0) queue_request(REQ_TICK, PIN_W'($urandom()));
         queue_request(REQ_ARM, PIN_W'($urandom()));
         made++;
         // keep some pins off target for the whole sequence so higher pins get a chance
         spoil = PIN_W'($urandom());
         run_len = $urandom_range(1, run_max);
         repeat (run_len) begin
            case ($urandom_range(0, 15))
               0:       levels = PIN_W'($urandom());
               1, 2, 3: levels = cfg_target ^ spoil ^ (PIN_W'(1) << $urandom_range(0, PIN_W - 1));
               default: levels = cfg_target ^ spoil;
            endcase
            if ($urandom_range(0, 29) == 0) queue_request(REQ_ARM, levels);
            else queue_request(REQ_TICK, levels);
            made++;
         end
      end
   endtask

   // Hold until every item is accepted and every outcome has arrived, then let the pipe settle.
   task automatic wait_until_drained();
      while (accepted_count != queued_count || outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all pins watched: idle ticks, debounce win, restart on mismatch, re-arm, timeout
      apply_settings(8'hFF, 8'hA5, 16'd2, 32'd5, 1'b1);
      queue_request(REQ_TICK, 8'hFF);
      queue_request(REQ_TICK, 8'h00);
      queue_request(REQ_ARM, 8'h00);
      queue_request(REQ_TICK, 8'h5A);
      repeat (3) queue_request(REQ_TICK, 8'hA5);
      queue_request(REQ_TICK, 8'hA5);
      queue_request(REQ_ARM, 8'hFF);
      queue_request(REQ_ARM, 8'h00);
      queue_request(REQ_TICK, 8'hDA);
      queue_request(REQ_TICK, 8'hDA);
      queue_request(REQ_TICK, 8'h5A);
      repeat (3) queue_request(REQ_TICK, 8'hDA);
      queue_request(REQ_ARM, 8'h00);
      repeat (7) queue_request(REQ_TICK, 8'h5A);
      wait_until_drained();

      // zero debounce and zero timeout: only the lowest enabled pin may win on expiry
      apply_settings(8'h0C, 8'hFF, 16'd0, 32'd0, 1'b1);
      queue_request(REQ_ARM, 8'h00);
      queue_request(REQ_TICK, 8'h00);
      queue_request(REQ_TICK, 8'h08);
      queue_request(REQ_ARM, 8'hFF);
      queue_request(REQ_TICK, 8'h04);
      wait_until_drained();

      // random phases across register settings
      apply_settings(8'hFF, 8'($urandom()), 16'd1, 32'd6, 1'b1);
      queue_wait_sequences(150, 10);
      wait_until_drained();

      apply_settings(8'($urandom_range(1, 255)), 8'($urandom()), 16'd3, 32'hFFFF_FFFF, 1'b1);
      queue_wait_sequences(150, 14);
      wait_until_drained();

      apply_settings(8'($urandom()), 8'($urandom()), 16'd0, 32'd2, 1'b0);
      queue_wait_sequences(150, 6);
      wait_until_drained();

      apply_settings(8'h80, 8'h00, 16'd4, 32'd9, 1'b1);
      queue_wait_sequences(100, 16);
      wait_until_drained();

      // back-to-back results against a long receiver hold
      apply_settings(8'hFF, 8'($urandom()), 16'd0, 32'd0, 1'b0);
      idle_on = 1'b0;
      hold_request = 1'b1;
      queue_wait_sequences(120, 1);
      wait_until_drained();
      idle_on = 1'b1;

      apply_settings(8'($urandom()), 8'($urandom()), 16'hFFFF, 32'($urandom_range(5, 40)), 1'b1);
      queue_wait_sequences(150, 40);
      wait_until_drained();

      // no pins watched: the wait never ends
      apply_settings(8'h00, 8'($urandom()), 16'd2, 32'd3, 1'b1);
      queue_wait_sequences(40, 8);
      wait_until_drained();

      apply_settings(8'($urandom()), 8'($urandom()), 16'($urandom_range(0, 5)),
                     32'($urandom_range(0, 20)), 1'($urandom()));
      queue_wait_sequences(300, 12);
      wait_until_drained();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
